### sv/assert_macros.svh
// Assertion helper macros shared by the lane assignment RTL.
// Needs clk and rst_n (synchronous, active low) visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ffla_pkg.sv
// Shared types, constants and the overlap test for the lane assignment block.
// No dependencies.
package ffla_pkg;

  localparam int POS_W = 16;              // interval start / width
  localparam int SPC_W = 8;               // lane spacing register
  localparam int IDX_W = 4;               // lane index result field
  localparam int TOP_W = 12;              // top position result field
  localparam logic [SPC_W-1:0] LANE_SPACING_RST = 8'd30;

  // Broadcast from the controller to every lane cell.
  typedef struct packed {
    logic clr;      // new request: drop conflict flag
    logic rd_en;    // scan read of one slot
  } scan_ctl_t;

  // What a lane cell reports when it takes the request.
  typedef struct packed {
    logic hit;
    logic opened;
  } cell_res_t;

  // Stored [a, a+w) against new [s, s+n), sums at 17 bits.
  function automatic logic overlaps(input logic [POS_W-1:0] a, input logic [POS_W-1:0] w,
                                    input logic [POS_W:0] s, input logic [POS_W:0] se);
    logic [POS_W:0] ae;
    logic [POS_W:0] az;
    az = {1'b0, a};
    ae = az + {1'b0, w};
    return ((az <= s) && (s < ae)) || ((az < se) && (se <= ae)) ||
           ((s <= az) && (ae <= se));
  endfunction

endpackage

### sv/ffla_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ffla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ffla_cell.sv
// One lane: its stored intervals, fill count, open flag and scan result.
// Depends on ffla_pkg, ffla_ram and assert_macros.svh.
module ffla_cell #(
  parameter int SLOTS = 16,
  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ffla_pkg::scan_ctl_t      ctl,
  input  logic [SAW-1:0]           rd_addr,
  input  logic [ffla_pkg::POS_W-1:0] req_start,
  input  logic [ffla_pkg::POS_W-1:0] req_width,
  input  logic [ffla_pkg::POS_W:0]   req_end,
  input  logic                     tok_in,
  output logic                     tok_out,
  output ffla_pkg::cell_res_t      res
);
  import ffla_pkg::*;
  `include "assert_macros.svh"

  localparam int FW  = $clog2(SLOTS + 1);

  logic [FW-1:0]      fill_r;
  logic               open_r;
  logic               conflict_r;
  logic               tok_out_r;
  logic               rd_vld_r;
  logic [SAW-1:0]     rd_k_r;
  logic [2*POS_W-1:0] rd_data;
  logic               full;
  logic               takes;
  logic               hit;
  logic               clash;

  ffla_ram #(.WIDTH(2*POS_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (hit),
    .waddr (fill_r[SAW-1:0]),
    .wdata ({req_start, req_width}),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // only slots below the fill count hold intervals
  assign clash = rd_vld_r && (FW'(rd_k_r) < fill_r) &&
                 overlaps(rd_data[2*POS_W-1:POS_W], rd_data[POS_W-1:0],
                          {1'b0, req_start}, req_end);

  assign full  = (fill_r == FW'(SLOTS));
  assign takes = !open_r || (!full && !conflict_r);
  assign hit   = tok_in && takes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      open_r     <= 1'b0;
      conflict_r <= 1'b0;
      tok_out_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r  <= ctl.rd_en;
      tok_out_r <= tok_in && !takes;
      if (ctl.clr) begin
        conflict_r <= 1'b0;
      end else if (clash) begin
        conflict_r <= 1'b1;
      end
      if (hit) begin
        open_r <= 1'b1;
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_k_r <= rd_addr;
    end
  end

  assign tok_out = tok_out_r;
  assign res     = '{hit: hit, opened: !open_r};

  `ASSERT_ALWAYS(a_fill_bound, fill_r <= FW'(SLOTS), "lane fill count above slot count")
  `ASSERT_IMPL(a_closed_empty, !open_r, fill_r == '0, "unopened lane holds intervals")
  `ASSERT_NEXT(a_hit_fill, hit, fill_r == $past(fill_r) + 1'b1, "fill not bumped on take")

endmodule

### sv/first_fit_interval_lane_assign_core.sv
// Top level: request controller, lane cell chain and result register.
// Depends on ffla_pkg, ffla_cell (with ffla_ram) and assert_macros.svh.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-----------------------------
//  request  | in_interval_start, in_interval_width         | start && !busy
//  result   | out_lane_index, out_top_position,            | out_valid, one cycle strobe
//           | out_opened_lane, out_store_full              |
//  config   | cfg_wr_data                                  | cfg_wr_en
//
// busy stays high from acceptance until the result is registered. The slot scan comes
// first (one RAM read per lane per cycle), then the drain state, then the take token
// walks the lane chain one cell per cycle until a lane takes the request or the token
// leaves the last cell. out_valid rises the cycle busy falls.
// Synchronous reset clears lanes and fill counts at once; there is no clearing pass.
// Results cannot be stalled; a new request is accepted in the out_valid cycle.
module first_fit_interval_lane_assign_core #(
  parameter int LANES          = 16,
  parameter int SLOTS_PER_LANE = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ffla_pkg::POS_W-1:0]  in_interval_start,
  input  logic [ffla_pkg::POS_W-1:0]  in_interval_width,
  output logic                        out_valid,
  output logic [ffla_pkg::IDX_W-1:0]  out_lane_index,
  output logic [ffla_pkg::TOP_W-1:0]  out_top_position,
  output logic                        out_opened_lane,
  output logic                        out_store_full,
  input  logic                        cfg_wr_en,
  input  logic [ffla_pkg::SPC_W-1:0]  cfg_wr_data
);
  import ffla_pkg::*;
  `include "assert_macros.svh"

  localparam int SAW = (SLOTS_PER_LANE > 1) ? $clog2(SLOTS_PER_LANE) : 1;
  localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PW  = LW + 1 + SPC_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_PICK} state_t;

  state_t             state_r;
  logic [SAW-1:0]     scan_k_r;
  logic [POS_W-1:0]   req_start_r;
  logic [POS_W-1:0]   req_width_r;
  logic [POS_W:0]     req_end_r;
  logic [SPC_W-1:0]   spacing_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   lane_idx_r;
  logic [TOP_W-1:0]   top_pos_r;
  logic               opened_r;
  logic               full_r;

  scan_ctl_t          ctl;
  logic               accept;
  logic [LANES:0]     tok_c;
  logic               tok0_r;
  cell_res_t          res [LANES];
  logic [LANES-1:0]   hit_vec;
  logic               any_hit;
  logic               any_opened;
  logic [LW-1:0]      lane_sel;
  logic [PW-1:0]      top_full;
  logic               pick_wait;
  logic               full_res;

  assign accept    = start && (state_r == S_IDLE);
  assign ctl       = '{clr: accept, rd_en: (state_r == S_SCAN)};
  assign tok_c[0]  = tok0_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ffla_cell #(.SLOTS(SLOTS_PER_LANE)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .rd_addr   (scan_k_r),
      .req_start (req_start_r),
      .req_width (req_width_r),
      .req_end   (req_end_r),
      .tok_in    (tok_c[i]),
      .tok_out   (tok_c[i+1]),
      .res       (res[i])
    );
    assign hit_vec[i] = res[i].hit;
  end

  // at most one cell holds the token, so an OR over lanes encodes the winner
  always_comb begin
    lane_sel   = '0;
    any_opened = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (res[i].hit) begin
        lane_sel   = lane_sel | LW'(i);
        any_opened = any_opened | res[i].opened;
      end
    end
  end

  assign any_hit  = |hit_vec;
  assign top_full = PW'({1'b0, lane_sel} + 1'b1) * PW'(spacing_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_k_r    <= '0;
      tok0_r      <= 1'b0;
      spacing_r   <= LANE_SPACING_RST;
      out_valid_r <= 1'b0;
      lane_idx_r  <= '0;
      top_pos_r   <= '0;
      opened_r    <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      tok0_r      <= 1'b0;
      if (cfg_wr_en) begin
        spacing_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            scan_k_r <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_k_r == SAW'(SLOTS_PER_LANE - 1)) begin
            state_r <= S_DRAIN;
          end else begin
            scan_k_r <= scan_k_r + 1'b1;
          end
        end
        S_DRAIN: begin
          tok0_r  <= 1'b1;
          state_r <= S_PICK;
        end
        S_PICK: begin
          if (any_hit || tok_c[LANES]) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (any_hit) begin
              lane_idx_r <= IDX_W'(lane_sel);
              top_pos_r  <= TOP_W'(top_full);
              opened_r   <= any_opened;
              full_r     <= 1'b0;
            end else begin
              lane_idx_r <= '0;
              top_pos_r  <= '0;
              opened_r   <= 1'b0;
              full_r     <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_start_r <= in_interval_start;
      req_width_r <= in_interval_width;
      req_end_r   <= {1'b0, in_interval_start} + {1'b0, in_interval_width};
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_lane_index   = lane_idx_r;
  assign out_top_position = top_pos_r;
  assign out_opened_lane  = opened_r;
  assign out_store_full   = full_r;

  assign pick_wait = (state_r == S_PICK) && !any_hit && !tok_c[LANES];
  assign full_res  = out_valid_r && full_r;

  `ASSERT_ALWAYS(a_one_taker, $onehot0(hit_vec), "more than one lane took the request")
  `ASSERT_IMPL(a_out_idle, out_valid_r, state_r == S_IDLE, "result while still working")
  `ASSERT_NEXT(a_pick_hold, pick_wait, state_r == S_PICK, "token lost in lane chain")
  `ASSERT_IMPL(a_full_zero, full_res, {lane_idx_r, top_pos_r, opened_r} == '0, "full, fields set")

endmodule
